### src/bitplane_text_glyph_writer_unit_assert.svh
// Assertion macros used by the glyph writer datapath.
// Each macro expects clk and arst_n in scope.
`ifndef BITPLANE_TEXT_GLYPH_WRITER_UNIT_ASSERT_SVH
`define BITPLANE_TEXT_GLYPH_WRITER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTGW_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTGW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/btgw_pkg.sv
package btgw_pkg;

	localparam int ADDR_W = 24;

	// Input item fields
	typedef struct packed {
		logic       mode;
		logic [10:0] font_address;
		logic [7:0] font_byte;
		logic [7:0] character;
		logic       first_char;
		logic [8:0] x_position;
		logic [7:0] y_position;
		logic [3:0] colour;
		logic       colour_mode;
	} in_item_t;

	// Result item fields
	typedef struct packed {
		logic [ADDR_W-1:0] write_address;
		logic [7:0]        write_byte;
		logic              last;
	} out_item_t;

	// Microcode step addresses
	localparam logic [2:0] STEP_WAIT   = 3'd0;
	localparam logic [2:0] STEP_SELECT = 3'd1;
	localparam logic [2:0] STEP_PTR    = 3'd2;
	localparam logic [2:0] STEP_INIT   = 3'd3;
	localparam logic [2:0] STEP_EMIT   = 3'd4;
	localparam logic [2:0] STEP_ADV    = 3'd5;

	// Jump conditions
	localparam logic [2:0] COND_NEVER     = 3'd0;
	localparam logic [2:0] COND_ALWAYS    = 3'd1;
	localparam logic [2:0] COND_NO_DRAW   = 3'd2;
	localparam logic [2:0] COND_NOT_FIRST = 3'd3;
	localparam logic [2:0] COND_NOT_DONE  = 3'd4;

	// Glyph code offset and pointer steps
	localparam logic [7:0]        GLYPH_OFFSET  = 8'd32;
	localparam logic [ADDR_W-1:0] PTR_STEP_EVEN = 24'd1;
	localparam logic [ADDR_W-1:0] PTR_STEP_ODD  = 24'd7;

	// One control word
	typedef struct packed {
		logic       ready;
		logic       ptr_load;
		logic       row_init;
		logic       emit;
		logic       step_ptr;
		logic [2:0] cond;
		logic [2:0] target;
	} ctrl_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic draw_go;
		logic first;
		logic done;
	} stat_t;

	// Control store
	function automatic ctrl_t ucode(input logic [2:0] step);
		ctrl_t cw;
		cw = '0;
		unique case (step)
			STEP_WAIT: begin
				cw.ready  = 1'b1;
				cw.cond   = COND_NO_DRAW;
				cw.target = STEP_WAIT;
			end
			STEP_SELECT: begin
				cw.cond   = COND_NOT_FIRST;
				cw.target = STEP_INIT;
			end
			STEP_PTR: begin
				cw.ptr_load = 1'b1;
				cw.cond     = COND_NEVER;
				cw.target   = STEP_WAIT;
			end
			STEP_INIT: begin
				cw.row_init = 1'b1;
				cw.cond     = COND_NEVER;
				cw.target   = STEP_WAIT;
			end
			STEP_EMIT: begin
				cw.emit   = 1'b1;
				cw.cond   = COND_NOT_DONE;
				cw.target = STEP_EMIT;
			end
			STEP_ADV: begin
				cw.step_ptr = 1'b1;
				cw.cond     = COND_ALWAYS;
				cw.target   = STEP_WAIT;
			end
			default: begin
				cw.cond   = COND_ALWAYS;
				cw.target = STEP_WAIT;
			end
		endcase
		return cw;
	endfunction

endpackage

### src/btgw_seq.sv
module btgw_seq
	import btgw_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	logic [2:0] step_q;
	logic       jump;

	assign ctrl = ucode(step_q);

	// Evaluate the jump condition of the current word
	always_comb begin
		unique case (ctrl.cond)
			COND_NEVER:     jump = 1'b0;
			COND_ALWAYS:    jump = 1'b1;
			COND_NO_DRAW:   jump = !stat.draw_go;
			COND_NOT_FIRST: jump = !stat.first;
			COND_NOT_DONE:  jump = !stat.done;
			default:        jump = 1'b1;
		endcase
	end

	// Advance or jump the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else if (jump) begin
			step_q <= ctrl.target;
		end else begin
			step_q <= step_q + 3'd1;
		end
	end

endmodule

### src/btgw_datapath.sv
`include "bitplane_text_glyph_writer_unit_assert.svh"

module btgw_datapath
	import btgw_pkg::*;
#(
	parameter int LINE_BYTES  = 160,
	parameter int GLYPH_COUNT = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctrl,
	output stat_t             stat,
	input  logic              cfg_write,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              in_valid,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_item
);

	localparam int STORE_DEPTH = GLYPH_COUNT * 8;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int PROD_W      = $clog2(255 * LINE_BYTES + 1);
	localparam logic [ADDR_W-1:0] LINE_STEP = ADDR_W'(LINE_BYTES);

	logic [7:0] font_mem [STORE_DEPTH];

	logic [ADDR_W-1:0] base_q, ptr_q, row_base_q;
	logic              odd_q, cmode_q, first_q, glyph_ok_q;
	logic [3:0]        colour_q;
	logic [7:0]        glyph_q, xoff_q, rd_q;
	logic [PROD_W-1:0] prod_q;
	logic [2:0]        row_q, row_rd;
	logic [1:0]        plane_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic       in_fire, draw_fire, load_fire;
	logic [7:0] glyph;
	logic       slot_free, emit_fire, plane_last, row_adv, last_w, plane_on;
	logic [10:0] rd_full;
	logic [AW-1:0] rd_addr;

	assign in_fire   = in_valid && ctrl.ready;
	assign draw_fire = in_fire && in_item.mode;
	assign load_fire = in_fire && !in_item.mode && (int'(in_item.font_address) < STORE_DEPTH);
	assign glyph     = in_item.character - GLYPH_OFFSET;

	assign slot_free  = !out_valid_q || out_ready;
	assign emit_fire  = ctrl.emit && slot_free;
	assign plane_last = !cmode_q || (plane_q == 2'd3);
	assign row_adv    = emit_fire && plane_last;
	assign last_w     = (row_q == 3'd7) && plane_last;
	assign plane_on   = cmode_q ? colour_q[plane_q] : 1'b1;

	// Pick the row to fetch for the next cycle
	always_comb begin
		priority if (ctrl.row_init) begin
			row_rd = 3'd0;
		end else if (row_adv) begin
			row_rd = row_q + 3'd1;
		end else begin
			row_rd = row_q;
		end
	end
	assign rd_full = {glyph_q, row_rd};
	assign rd_addr = rd_full[AW-1:0];

	assign stat.draw_go = draw_fire;
	assign stat.first   = first_q;
	assign stat.done    = emit_fire && last_w;

	// Font store: load on a mode 0 item, read one row a cycle
	always_ff @(posedge clk) begin
		if (load_fire) begin
			font_mem[in_item.font_address[AW-1:0]] <= in_item.font_byte;
		end
		rd_q <= font_mem[rd_addr];
	end

	// Capture draw item fields
	always_ff @(posedge clk) begin
		if (draw_fire) begin
			first_q    <= in_item.first_char;
			glyph_q    <= glyph;
			glyph_ok_q <= int'(glyph) < GLYPH_COUNT;
			prod_q     <= PROD_W'(32'(in_item.y_position) * LINE_BYTES);
			xoff_q     <= {in_item.x_position[8:4], 2'b00, in_item.x_position[3]};
		end
	end

	// Architectural state: base register, pointer, latched colour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			ptr_q    <= '0;
			odd_q    <= 1'b0;
			colour_q <= '0;
			cmode_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				base_q <= cfg_data;
			end
			if (draw_fire && in_item.first_char) begin
				colour_q <= in_item.colour;
				cmode_q  <= in_item.colour_mode;
			end
			if (ctrl.ptr_load) begin
				ptr_q <= base_q + ADDR_W'(prod_q) + ADDR_W'(xoff_q);
				odd_q <= xoff_q[0];
			end else if (ctrl.step_ptr) begin
				ptr_q <= ptr_q + (odd_q ? PTR_STEP_ODD : PTR_STEP_EVEN);
				odd_q <= !odd_q;
			end
		end
	end

	// Row and plane counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			plane_q <= '0;
		end else if (ctrl.row_init) begin
			row_q   <= '0;
			plane_q <= '0;
		end else if (emit_fire) begin
			if (plane_last) begin
				plane_q <= '0;
				row_q   <= row_q + 3'd1;
			end else begin
				plane_q <= plane_q + 2'd1;
			end
		end
	end

	// Row address follows the row counter
	always_ff @(posedge clk) begin
		if (ctrl.row_init) begin
			row_base_q <= ptr_q;
		end else if (row_adv) begin
			row_base_q <= row_base_q + LINE_STEP;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_q.write_address <= row_base_q + {{(ADDR_W-3){1'b0}}, plane_q, 1'b0};
			out_q.write_byte    <= (glyph_ok_q && plane_on) ? rd_q : 8'h00;
			out_q.last          <= last_w;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`BTGW_ASSERT_SAME(a_plain_plane0, emit_fire && !cmode_q, plane_q == 2'd0, "plain mode off plane zero")
	`BTGW_ASSERT_NEXT(a_step_toggles, ctrl.step_ptr, odd_q != $past(odd_q), "odd half did not toggle")
	`BTGW_ASSERT_NEXT(a_done_leaves_emit, emit_fire && last_w, !ctrl.emit, "emit kept after last write")

endmodule

### src/bitplane_text_glyph_writer_unit.sv
// Channel  Handshake            Payload     Direction
// in       in_valid/in_ready    in_item     into block
// out      out_valid/out_ready  out_item    out of block
// cfg      cfg_write            cfg_data    into block
//
// A draw item runs select, pointer load (a string's first character only), row init,
// emit and pointer advance, issuing n = 8 plain or 32 colour writes; the microcode
// program steps one control word per cycle and issues one write per cycle unless the
// output stalls. The font store is one memory; its registered read fetches the next
// row after each row's last write. Reset clears pointer, phase, latched colour and
// base; the font store holds garbage. A stall holds the emit step; the next item is
// taken at the wait step even while the last write still sits in the output register.
module bitplane_text_glyph_writer_unit
	import btgw_pkg::*;
#(
	parameter int LINE_BYTES  = 160,
	parameter int GLYPH_COUNT = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_item
);

	ctrl_t ctrl;
	stat_t stat;

	btgw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	btgw_datapath #(
		.LINE_BYTES  (LINE_BYTES),
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	assign in_ready = ctrl.ready;

endmodule
